[hw/rtl/binary_frame_encoder_fletcher8_macros.svh]
// assertion macros shared by the frame encoder rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef BINARY_FRAME_ENCODER_FLETCHER8_MACROS_SVH
`define BINARY_FRAME_ENCODER_FLETCHER8_MACROS_SVH

`ifndef ASSERT_OFF
`define BFE_F8_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bfe_f8 check failed");
`define BFE_F8_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfe_f8 implication failed");
`else
`define BFE_F8_ASSERT(lbl, clk, rst, prop)
`define BFE_F8_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/bfe_f8_pkg.sv]
// types and constants of the fletcher-8 frame encoder
// no dependencies
package bfe_f8_pkg;

   localparam int MAX_RESULTS = 8;
   localparam int CNT_W       = 4;
   localparam int CAP_W       = 17;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;
   localparam logic [CNT_W-1:0] HEAD_BYTES  = 4'd6;
   localparam logic [CNT_W-1:0] CHECK_BYTES = 4'd2;
   localparam logic [CAP_W-1:0] FRAME_OVERHEAD = 17'd8;
   localparam logic [CAP_W-1:0] CAP_RESET = 17'd65543;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TOO_BIG = 2'd1,
      STATUS_ORDER   = 2'd2
   } status_type;

   // one burst of result words handed to the output queue
   typedef struct packed {
      logic                              load;
      logic [CNT_W-1:0]                  count;
      logic                              last_end;
      status_type                        status;
      logic [MAX_RESULTS-1:0][7:0]       bytes;
   } burst_type;

endpackage

[hw/rtl/bfe_f8_ifs.sv]
// valid/ready channel interfaces for request and response words
// depends on bfe_f8_pkg
interface bfe_f8_req_if;
   import bfe_f8_pkg::*;
   logic        valid;
   logic        ready;
   cmd_type     cmd;
   logic [7:0]  msg_class;
   logic [7:0]  msg_id;
   logic [15:0] payload_len;
   logic [7:0]  data_byte;
   modport source (output valid, cmd, msg_class, msg_id, payload_len, data_byte,
                   input ready);
   modport sink   (input valid, cmd, msg_class, msg_id, payload_len, data_byte,
                   output ready);
endinterface

interface bfe_f8_rsp_if;
   import bfe_f8_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   status_type status;
   modport source (output valid, out_byte, frame_end, status, input ready);
   modport sink   (input valid, out_byte, frame_end, status, output ready);
endinterface

[hw/rtl/bfe_f8_burst.sv]
// output queue: holds one burst of up to eight result words and shifts them out
// depends on bfe_f8_pkg, bfe_f8_rsp_if and the macro header
`include "binary_frame_encoder_fletcher8_macros.svh"

module bfe_f8_burst (
   input  logic                  clock,
   input  logic                  reset,
   input  bfe_f8_pkg::burst_type burst_ld,
   output logic                  can_load,
   bfe_f8_rsp_if.source          rsp_ch
);
   import bfe_f8_pkg::*;

   logic [CNT_W-1:0]            count_ff, count_in;
   logic [MAX_RESULTS-1:0][7:0] bytes_ff, bytes_in;
   logic                        end_ff, end_in;
   status_type                  status_ff, status_in;
   logic                        take;

   assign take     = rsp_ch.valid && rsp_ch.ready;
   assign can_load = (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_ch.ready);

   assign rsp_ch.valid     = (count_ff != '0);
   assign rsp_ch.out_byte  = bytes_ff[0];
   assign rsp_ch.frame_end = end_ff && (count_ff == CNT_W'(1));
   assign rsp_ch.status    = status_ff;

   always_comb begin
      count_in  = count_ff;
      bytes_in  = bytes_ff;
      end_in    = end_ff;
      status_in = status_ff;
      if (burst_ld.load) begin
         count_in  = burst_ld.count;
         bytes_in  = burst_ld.bytes;
         end_in    = burst_ld.last_end;
         status_in = burst_ld.status;
      end else if (take) begin
         count_in = count_ff - CNT_W'(1);
         bytes_in = bytes_ff >> 8;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      bytes_ff  <= bytes_in;
      end_ff    <= end_in;
      status_ff <= status_in;
   end

   `BFE_F8_ASSERT(a_count_range, clock, reset, count_ff <= CNT_W'(MAX_RESULTS))
   `BFE_F8_ASSERT_IMPL(a_load_when_free, clock, reset, burst_ld.load, can_load)
   `BFE_F8_ASSERT(a_take_decrements, clock, reset,
      (take && !burst_ld.load) |=> (count_ff == $past(count_ff) - CNT_W'(1)))

endmodule

[hw/rtl/binary_frame_encoder_fletcher8.sv]
// fletcher-8 frame encoder: first response word is registered, out in the cycle after accept
// payload word: one output word, three at frame end; one request per cycle unless stalled
// start word: six response words, eight for an empty payload; single word on errors
// next request is taken in the cycle the burst queue's last word leaves (one output port)
// synchronous reset clears frame state and the queue, capacity returns to 65543
`include "binary_frame_encoder_fletcher8_macros.svh"

module binary_frame_encoder_fletcher8 (
   input  logic                          clock,
   input  logic                          reset,
   bfe_f8_req_if.sink                    req_ch,
   bfe_f8_rsp_if.source                  rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bfe_f8_pkg::CAP_W-1:0]  csr_wr_data
);
   import bfe_f8_pkg::*;

   // capacity register and frame state
   logic [CAP_W-1:0] cap_ff;
   logic             open_ff, open_in;
   logic [15:0]      left_ff, left_in;
   logic [7:0]       sum_a_ff, sum_a_in;
   logic [7:0]       sum_b_ff, sum_b_in;

   logic             can_load;
   logic             accept;
   burst_type        burst;

   // running sums over the four header bytes that are checksummed
   logic [7:0] ha1, ha2, ha3, ha4;
   logic [7:0] hb1, hb2, hb3, hb4;
   // running sums for one payload word
   logic [7:0] pa, pb;
   logic       too_big;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && req_ch.ready;

   // header checksum chain: class, id, length low, length high
   assign ha1 = req_ch.msg_class;
   assign hb1 = ha1;
   assign ha2 = ha1 + req_ch.msg_id;
   assign hb2 = hb1 + ha2;
   assign ha3 = ha2 + req_ch.payload_len[7:0];
   assign hb3 = hb2 + ha3;
   assign ha4 = ha3 + req_ch.payload_len[15:8];
   assign hb4 = hb3 + ha4;

   assign pa = sum_a_ff + req_ch.data_byte;
   assign pb = sum_b_ff + pa;

   // whole frame including sync, header and checksum against capacity
   assign too_big = ({1'b0, req_ch.payload_len} + FRAME_OVERHEAD) > cap_ff;

   always_comb begin
      // default: single error word for an out-of-order request
      burst.load     = accept;
      burst.count    = CNT_W'(1);
      burst.last_end = 1'b1;
      burst.status   = STATUS_ORDER;
      burst.bytes    = '0;
      open_in  = open_ff;
      left_in  = left_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;

      if (req_ch.cmd == CMD_START) begin
         if (open_ff) begin
            // start while a frame is open: flagged, frame goes on
         end else if (too_big) begin
            burst.status = STATUS_TOO_BIG;
         end else begin
            burst.status   = STATUS_OK;
            burst.bytes[0] = SYNC_FIRST;
            burst.bytes[1] = SYNC_SECOND;
            burst.bytes[2] = req_ch.msg_class;
            burst.bytes[3] = req_ch.msg_id;
            burst.bytes[4] = req_ch.payload_len[7:0];
            burst.bytes[5] = req_ch.payload_len[15:8];
            burst.bytes[6] = ha4;
            burst.bytes[7] = hb4;
            sum_a_in = ha4;
            sum_b_in = hb4;
            if (req_ch.payload_len == '0) begin
               // empty payload closes the frame right away
               burst.count    = HEAD_BYTES + CHECK_BYTES;
               burst.last_end = 1'b1;
               open_in        = 1'b0;
               left_in        = '0;
            end else begin
               burst.count    = HEAD_BYTES;
               burst.last_end = 1'b0;
               open_in        = 1'b1;
               left_in        = req_ch.payload_len;
            end
         end
      end else begin
         if (open_ff) begin
            burst.status   = STATUS_OK;
            burst.bytes[0] = req_ch.data_byte;
            burst.bytes[1] = pa;
            burst.bytes[2] = pb;
            sum_a_in = pa;
            sum_b_in = pb;
            if (left_ff == 16'd1) begin
               // last payload word: append both checksum bytes
               burst.count    = CNT_W'(1) + CHECK_BYTES;
               burst.last_end = 1'b1;
               open_in        = 1'b0;
               left_in        = '0;
            end else begin
               burst.last_end = 1'b0;
               left_in        = left_ff - 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         open_ff  <= 1'b0;
         left_ff  <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (accept) begin
            open_ff  <= open_in;
            left_ff  <= left_in;
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   // response word queue
   bfe_f8_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .burst_ld (burst),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

   `BFE_F8_ASSERT_IMPL(a_open_has_bytes, clock, reset, open_ff, left_ff != '0)
   `BFE_F8_ASSERT_IMPL(a_closed_no_bytes, clock, reset, !open_ff, left_ff == '0)
   `BFE_F8_ASSERT(a_last_word_closes, clock, reset,
      (accept && (req_ch.cmd == CMD_DATA) && open_ff && (left_ff == 16'd1)) |=> !open_ff)

endmodule

[verif/binary_frame_encoder_fletcher8_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the fletcher-8 frame encoder: directed table and random frames
// depends on bfe_f8_pkg, bfe_f8_ifs and binary_frame_encoder_fletcher8
module binary_frame_encoder_fletcher8_test;
   import bfe_f8_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int IDLE_PCT       = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_WORDS    = 13;
   localparam int NUM_PHASES     = 7;
   localparam int NUM_ROWS       = 20;
   localparam logic [CAP_W-1:0] CAP_MAX = '1;
   localparam logic [15:0]      LEN_MAX = 16'hFFFF;

   // one request word as seen on the input channel
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  msg_class;
      logic [7:0]  msg_id;
      logic [15:0] payload_len;
      logic [7:0]  data_byte;
   } req_word_type;

   // one response word as seen on the output channel
   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      status_type status;
   } rsp_word_type;

   // per request: a hand-typed response word that replaces the prediction
   typedef struct packed {
      logic         typed;
      rsp_word_type word;
   } word_note_type;

   typedef struct {
      logic [CAP_W-1:0] cap;
      req_word_type     req;
      word_note_type    note;
   } dir_row_type;

   localparam word_note_type UNTYPED      = '0;
   localparam word_note_type ORDER_NOTE   = '{1'b1, '{8'h00, 1'b1, STATUS_ORDER}};
   localparam word_note_type TOO_BIG_NOTE = '{1'b1, '{8'h00, 1'b1, STATUS_TOO_BIG}};

   // directed stimulus, walked in order; the capacity column is written when it changes
   dir_row_type dir_table [NUM_ROWS] = '{
      // payload word right after reset, no frame open
      '{CAP_RESET, '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'hFF}, ORDER_NOTE},
      // empty frames, all-zero and all-one header fields
      '{CAP_RESET, '{CMD_START, 8'h00, 8'h00, 16'h0000, 8'hFF}, UNTYPED},
      '{CAP_RESET, '{CMD_START, 8'hFF, 8'hFF, 16'h0000, 8'h00}, UNTYPED},
      // two-byte frame with a start arriving while it is open
      '{CAP_RESET, '{CMD_START, 8'h5A, 8'hA5, 16'h0002, 8'h00}, UNTYPED},
      '{CAP_RESET, '{CMD_START, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF}, ORDER_NOTE},
      '{CAP_RESET, '{CMD_DATA,  8'hFF, 8'hFF, 16'hFFFF, 8'h00}, UNTYPED},
      '{CAP_RESET, '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'hFF}, UNTYPED},
      '{CAP_RESET, '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'h7E}, ORDER_NOTE},
      // single payload byte closes at once
      '{CAP_RESET, '{CMD_START, 8'h01, 8'h80, 16'h0001, 8'h00}, UNTYPED},
      '{CAP_RESET, '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'h81}, UNTYPED},
      // capacity 10: two payload bytes fit exactly, three do not, max length must not wrap
      '{17'd10,    '{CMD_START, 8'h12, 8'h34, 16'h0003, 8'h00}, TOO_BIG_NOTE},
      '{17'd10,    '{CMD_START, 8'h00, 8'h00, 16'hFFFF, 8'h00}, TOO_BIG_NOTE},
      '{17'd10,    '{CMD_START, 8'h33, 8'hCC, 16'h0002, 8'h00}, UNTYPED},
      '{17'd10,    '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'h55}, UNTYPED},
      '{17'd10,    '{CMD_DATA,  8'h00, 8'h00, 16'h0000, 8'hAA}, UNTYPED},
      // capacity below the overhead rejects even an empty frame
      '{17'd7,     '{CMD_START, 8'h00, 8'h00, 16'h0000, 8'h00}, TOO_BIG_NOTE},
      // capacity equal to the overhead: only an empty frame fits; then capacity zero and the maximum
      '{FRAME_OVERHEAD, '{CMD_START, 8'hC3, 8'h3C, 16'h0000, 8'h00}, UNTYPED},
      '{FRAME_OVERHEAD, '{CMD_START, 8'hC3, 8'h3C, 16'h0001, 8'h00}, TOO_BIG_NOTE},
      '{17'd0,     '{CMD_START, 8'h00, 8'h00, 16'h0000, 8'h00}, TOO_BIG_NOTE},
      '{CAP_MAX,   '{CMD_START, 8'h80, 8'h01, 16'h0000, 8'h00}, UNTYPED}
   };

   logic [CAP_W-1:0] phase_caps [NUM_PHASES] = '{
      CAP_RESET, 17'd20, FRAME_OVERHEAD, CAP_MAX, 17'd0, 17'd7, 17'd0
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   bfe_f8_req_if req_bus ();
   bfe_f8_rsp_if rsp_bus ();

   binary_frame_encoder_fletcher8 u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // encoder model state: frame fields updated on every accepted request word, capacity on csr writes
   logic             open_m;
   logic [15:0]      left_m;
   logic [7:0]       sum_a_m;
   logic [7:0]       sum_b_m;
   logic [CAP_W-1:0] cap_m;

   rsp_word_type  predicted [$];        // words caused by the request just accepted
   rsp_word_type  frame_words_due [$];  // encoded words still to come out, oldest first
   word_note_type offered_notes [$];    // one entry per request word not yet accepted

   logic [CAP_W-1:0] cur_cap;        // capacity as last written by the stimulus
   int  error_count = 0;
   int  words_seen  = 0;
   int  phase_words = 0;
   int  quiet_cycles = 0;
   bit  steady = 1'b0;               // no idling on either side while set
   bit  hold_request = 1'b0;         // asks the receiver for one long hold-off

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void emit(logic [7:0] b, logic e, status_type s);
      rsp_word_type w;
      w.out_byte  = b;
      w.frame_end = e;
      w.status    = s;
      predicted.push_back(w);
   endfunction

   // byte that enters the running fletcher sums
   function automatic void emit_summed(logic [7:0] b);
      sum_a_m = sum_a_m + b;
      sum_b_m = sum_b_m + sum_a_m;
      emit(b, 1'b0, STATUS_OK);
   endfunction

   // two checksum bytes close the frame
   function automatic void emit_checksum();
      emit(sum_a_m, 1'b0, STATUS_OK);
      emit(sum_b_m, 1'b1, STATUS_OK);
      open_m = 1'b0;
      left_m = '0;
   endfunction

   function automatic void encode_word(req_word_type r);
      predicted.delete();
      if (r.cmd == CMD_START) begin
         if (open_m) begin
            // start while open: flagged, open frame untouched
            emit(8'h00, 1'b1, STATUS_ORDER);
         end else if (int'(r.payload_len) + int'(FRAME_OVERHEAD) > int'(cap_m)) begin
            emit(8'h00, 1'b1, STATUS_TOO_BIG);
         end else begin
            sum_a_m = '0;
            sum_b_m = '0;
            emit(SYNC_FIRST, 1'b0, STATUS_OK);
            emit(SYNC_SECOND, 1'b0, STATUS_OK);
            emit_summed(r.msg_class);
            emit_summed(r.msg_id);
            emit_summed(r.payload_len[7:0]);
            emit_summed(r.payload_len[15:8]);
            if (r.payload_len == 16'h0000) begin
               emit_checksum();
            end else begin
               open_m = 1'b1;
               left_m = r.payload_len;
            end
         end
      end else if (!open_m) begin
         // payload word with no frame open
         emit(8'h00, 1'b1, STATUS_ORDER);
      end else begin
         emit_summed(r.data_byte);
         left_m = left_m - 16'd1;
         if (left_m == 16'h0000) begin
            emit_checksum();
         end
      end
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_mismatch(input string what);
      $display("mismatch at response word %0d: %s", words_seen, what);
      error_count++;
   endtask

   function automatic req_word_type random_word(cmd_type c);
      req_word_type w;
      w.cmd         = c;
      w.msg_class   = 8'($urandom);
      w.msg_id      = 8'($urandom);
      w.payload_len = 16'($urandom);
      w.data_byte   = 8'($urandom);
      return w;
   endfunction

   task automatic put_req(input req_word_type w);
      req_bus.cmd         = w.cmd;
      req_bus.msg_class   = w.msg_class;
      req_bus.msg_id      = w.msg_id;
      req_bus.payload_len = w.payload_len;
      req_bus.data_byte   = w.data_byte;
   endtask

   // called at a falling edge, returns at the falling edge after the word is taken;
   // valid stays high so that a following call can offer the next word back to back
   task automatic send_word(input req_word_type w, input word_note_type note);
      offered_notes.push_back(note);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         put_req(random_word(cmd_type'($urandom_range(1))));
         @(negedge clock);
      end
      put_req(w);
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      phase_words++;
   endtask

   // capacity changes only once the encoder has drained
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_bus.valid = 1'b0;
      while (frame_words_due.size() != 0 || offered_notes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      cur_cap   = value;
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      req_word_type w;
      int        roll;
      int        len;
      int        lo;
      logic [CAP_W-1:0] cap;

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      put_req('0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset   = 1'b0;
      cur_cap = CAP_RESET;

      // directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (dir_table[r].cap != cur_cap) write_capacity(dir_table[r].cap);
         send_word(dir_table[r].req, dir_table[r].note);
      end

      // random phases, one capacity setting each; mostly well-formed frames
      for (int p = 0; p < NUM_PHASES; p++) begin
         cap = (p == 4) ? CAP_W'($urandom_range(64, 9)) : phase_caps[p];
         write_capacity(cap);
         steady = (p == 3);
         // the receiver stalls for a long while here so the encoder backs up its input
         if (p == 1) hold_request = 1'b1;
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               // stray payload word outside a frame
               send_word(random_word(CMD_DATA), UNTYPED);
            end else if (roll < 15 && cur_cap < CAP_RESET) begin
               // start that cannot fit the capacity, any length up to the max
               lo = (int'(cur_cap) > 7) ? int'(cur_cap) - 7 : 0;
               w = random_word(CMD_START);
               w.payload_len = 16'($urandom_range(int'(LEN_MAX), lo));
               send_word(w, UNTYPED);
            end else begin
               len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
               w = random_word(CMD_START);
               w.payload_len = 16'(len);
               send_word(w, UNTYPED);
               if (len != 0 && len + int'(FRAME_OVERHEAD) <= int'(cur_cap)) begin
                  for (int i = 0; i < len; i++) begin
                     // now and then a start in the middle of an open frame
                     if ($urandom_range(11) == 0) send_word(random_word(CMD_START), UNTYPED);
                     send_word(random_word(CMD_DATA), UNTYPED);
                  end
               end
            end
         end
      end
      steady = 1'b0;
      req_bus.valid = 1'b0;

      // drain, then give stray words a chance to show up
      while (frame_words_due.size() != 0 || offered_notes.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
      if (error_count == 0 && frame_words_due.size() == 0) begin
         $display("binary_frame_encoder_fletcher8_test passed");
      end else begin
         $display("binary_frame_encoder_fletcher8_test failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // ready changes on the falling edge; one long hold-off when asked
   initial begin : receiver
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request  = 1'b0;
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // ---------------------------------------------------------------- monitor

   // samples both channels at the rising edge; predictions go in before the check so
   // a word taken in the same cycle only ever lands behind older expectations
   always @(posedge clock) begin : monitor
      req_word_type  acc;
      rsp_word_type  exp_w;
      word_note_type note;
      bit            moved;

      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            moved           = 1'b1;
            acc.cmd         = req_bus.cmd;
            acc.msg_class   = req_bus.msg_class;
            acc.msg_id      = req_bus.msg_id;
            acc.payload_len = req_bus.payload_len;
            acc.data_byte   = req_bus.data_byte;
            note = (offered_notes.size() != 0) ? offered_notes.pop_front() : UNTYPED;
            encode_word(acc);
            if (note.typed) begin
               frame_words_due.push_back(note.word);
            end else begin
               foreach (predicted[k]) frame_words_due.push_back(predicted[k]);
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (frame_words_due.size() == 0) begin
               report_mismatch($sformatf("unexpected word byte %h end %b status %0d",
                                         rsp_bus.out_byte, rsp_bus.frame_end,
                                         rsp_bus.status));
            end else begin
               exp_w = frame_words_due.pop_front();
               if (rsp_bus.out_byte !== exp_w.out_byte)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_bus.out_byte, exp_w.out_byte));
               if (rsp_bus.frame_end !== exp_w.frame_end)
                  report_mismatch($sformatf("frame_end %b, expected %b",
                                            rsp_bus.frame_end, exp_w.frame_end));
               if (rsp_bus.status !== exp_w.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_bus.status, exp_w.status));
            end
            words_seen++;
         end
         if (csr_wr_en) cap_m = csr_wr_data;
         // watchdog on cycles with no word moving on either channel
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("binary_frame_encoder_fletcher8_test failed");
            $finish;
         end
      end else begin
         open_m  = 1'b0;
         left_m  = '0;
         sum_a_m = '0;
         sum_b_m = '0;
         cap_m   = CAP_RESET;
      end
   end

endmodule

[binary_frame_encoder_fletcher8.f]
+incdir+hw/rtl
hw/rtl/bfe_f8_pkg.sv
hw/rtl/bfe_f8_ifs.sv
hw/rtl/bfe_f8_burst.sv
hw/rtl/binary_frame_encoder_fletcher8.sv
verif/binary_frame_encoder_fletcher8_test.sv
